/* sv/dts_pkg.sv */
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types, codes and sizes for the deadline task scheduler.
// ----------------------------------------------------------------------------
package dts_pkg;

  // Default sizes
  localparam int ACTIVE_DEPTH_DEF  = 16;
  localparam int OVERDUE_DEPTH_DEF = 32;
  localparam int TASK_ID_BITS_DEF  = 16;

  // Expired tasks reported per time check
  localparam int RESULT_LIMIT = 16;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Raw kind codes on the input
  localparam logic [2:0] KIND_CREATE    = 3'd0;
  localparam logic [2:0] KIND_DELETE    = 3'd1;
  localparam logic [2:0] KIND_TCHECK    = 3'd2;
  localparam logic [2:0] KIND_READ_ACT  = 3'd3;
  localparam logic [2:0] KIND_READ_LATE = 3'd4;

  // Status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_PREEMPT   = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_RANGE     = 3'd4;

  // Classified operation
  typedef enum logic [2:0] {
    OP_CREATE,
    OP_DELETE,
    OP_TCHECK,
    OP_READ_ACT,
    OP_READ_LATE,
    OP_NONE
  } op_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_NONE,
    S_CREATE,
    S_DEL_RD,
    S_DEL_CHK,
    S_DEL_DONE,
    S_PICK_RD,
    S_PICK_CHK,
    S_TC_RD,
    S_TC_CHK,
    S_TC_HIT,
    S_TC_END,
    S_RA,
    S_RA_DATA,
    S_RO,
    S_EMIT
  } seq_state_t;

  // One queued command
  typedef struct packed {
    op_t         op;
    logic [15:0] task_id;
    logic [31:0] rel_ms;
    logic [31:0] now_ms;
    logic [4:0]  idx;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [15:0] run_task_id;
    logic        run_valid;
    logic [15:0] demoted_task_id;
    logic [15:0] entry_task_id;
    logic [31:0] entry_created_ms;
    logic [31:0] entry_deadline_ms;
    logic        entry_valid;
    logic [4:0]  active_count;
    logic [15:0] overdue_count;
    logic [31:0] idle_time_ms;
    logic [2:0]  status;
    logic        last;
  } result_t;

endpackage

/* sv/deadline_task_scheduler_core.sv */
// ----------------------------------------------------------------------------
// deadline_task_scheduler_core
// Earliest-deadline-first scheduler: front decode, command queue, back end.
// ----------------------------------------------------------------------------
// Each command passes the queue, then the back end's idle, operation and emit
// states; reads with data add a data state. Delete scans slots in turn and,
// if it removes the running task, rescans all slots; a time check scans all
// slots, handles each expired task and rescans per expired running task.
// The back end finishes one command before taking the next; the queue holds two more.
// Reset: synchronous; empties the table, ring, counters and queue.
module deadline_task_scheduler_core
  import dts_pkg::*;
#(
  parameter int ACTIVE_DEPTH  = ACTIVE_DEPTH_DEF,
  parameter int OVERDUE_DEPTH = OVERDUE_DEPTH_DEF,
  parameter int TASK_ID_BITS  = TASK_ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] task_id,
  input  logic [31:0] relative_deadline_ms,
  input  logic [31:0] now_ms,
  input  logic [4:0]  entry_index,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] run_task_id,
  output logic        run_valid,
  output logic [15:0] demoted_task_id,
  output logic [15:0] entry_task_id,
  output logic [31:0] entry_created_ms,
  output logic [31:0] entry_deadline_ms,
  output logic        entry_valid,
  output logic [4:0]  active_count,
  output logic [15:0] overdue_count,
  output logic [31:0] idle_time_ms,
  output logic [2:0]  status,
  output logic        last
);

  logic    q_full, q_push, q_pop, q_nonempty;
  item_t   push_item, head_item;
  result_t res;

  dts_front u_front (
    .item_valid           (item_valid),
    .item_ready           (item_ready),
    .kind                 (kind),
    .task_id              (task_id),
    .relative_deadline_ms (relative_deadline_ms),
    .now_ms               (now_ms),
    .entry_index          (entry_index),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_item               (push_item)
  );

  dts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head_item (head_item)
  );

  dts_back #(
    .ACTIVE_DEPTH  (ACTIVE_DEPTH),
    .OVERDUE_DEPTH (OVERDUE_DEPTH),
    .TASK_ID_BITS  (TASK_ID_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .q_item       (head_item),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (res)
  );

  assign run_task_id       = res.run_task_id;
  assign run_valid         = res.run_valid;
  assign demoted_task_id   = res.demoted_task_id;
  assign entry_task_id     = res.entry_task_id;
  assign entry_created_ms  = res.entry_created_ms;
  assign entry_deadline_ms = res.entry_deadline_ms;
  assign entry_valid       = res.entry_valid;
  assign active_count      = res.active_count;
  assign overdue_count     = res.overdue_count;
  assign idle_time_ms      = res.idle_time_ms;
  assign status            = res.status;
  assign last              = res.last;

endmodule

/* sv/dts_front.sv */
// ----------------------------------------------------------------------------
// dts_front
// Input side: takes item beats and classifies the kind into an operation.
// ----------------------------------------------------------------------------
module dts_front
  import dts_pkg::*;
(
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] task_id,
  input  logic [31:0] relative_deadline_ms,
  input  logic [31:0] now_ms,
  input  logic [4:0]  entry_index,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  op_t op;

  // Kind decode; unused codes become a no-op
  always_comb begin
    case (kind)
      KIND_CREATE:    op = OP_CREATE;
      KIND_DELETE:    op = OP_DELETE;
      KIND_TCHECK:    op = OP_TCHECK;
      KIND_READ_ACT:  op = OP_READ_ACT;
      KIND_READ_LATE: op = OP_READ_LATE;
      default:        op = OP_NONE;
    endcase
  end

  assign item_ready     = !q_full;
  assign q_push         = item_valid && !q_full;
  assign q_item.op      = op;
  assign q_item.task_id = task_id;
  assign q_item.rel_ms  = relative_deadline_ms;
  assign q_item.now_ms  = now_ms;
  assign q_item.idx     = entry_index;

endmodule

/* sv/dts_queue.sv */
// ----------------------------------------------------------------------------
// dts_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module dts_queue
  import dts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output item_t head_item
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          store [QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr;
  logic [QW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign nonempty  = (count != '0);
  assign head_item = store[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

endmodule

/* sv/dts_back.sv */
// ----------------------------------------------------------------------------
// dts_back
// Back end: slot table, overdue ring, sequencer and result register.
// ----------------------------------------------------------------------------
module dts_back
  import dts_pkg::*;
#(
  parameter int ACTIVE_DEPTH  = ACTIVE_DEPTH_DEF,
  parameter int OVERDUE_DEPTH = OVERDUE_DEPTH_DEF,
  parameter int TASK_ID_BITS  = TASK_ID_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_nonempty,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int AW = $clog2(ACTIVE_DEPTH);
  localparam int LW = $clog2(OVERDUE_DEPTH);
  localparam int CW = $clog2(ACTIVE_DEPTH + 1);
  localparam int NW = $clog2(RESULT_LIMIT + 1);
  localparam int SW = TASK_ID_BITS + 64;
  localparam logic [63:0] ID_MASK = (64'd1 << TASK_ID_BITS) - 64'd1;
  localparam logic [AW-1:0] SLOT_LAST = AW'(ACTIVE_DEPTH - 1);
  localparam logic [LW-1:0] RING_LAST = LW'(OVERDUE_DEPTH - 1);

  // Slot table and overdue ring storage
  logic [SW-1:0] slot_mem [ACTIVE_DEPTH];
  logic [SW-1:0] ring_mem [OVERDUE_DEPTH];
  logic [SW-1:0] slot_rd, ring_rd;
  logic          slot_we, ring_we;
  logic [AW-1:0] slot_wa, slot_ra;
  logic [LW-1:0] ring_wa, ring_ra;
  logic [SW-1:0] slot_wd, ring_wd;

  // Control state
  seq_state_t        state, state_next;
  logic [ACTIVE_DEPTH-1:0] valid, valid_next;
  logic [CW-1:0]     active_cnt, active_cnt_next;
  logic              run_present, run_present_next;
  logic [AW-1:0]     run_slot, run_slot_next;
  logic [LW-1:0]     late_head, late_head_next;
  logic [15:0]       late_total, late_total_next;
  logic [31:0]       idle, idle_next;
  logic [31:0]       prev_now, prev_now_next;
  logic              have_pend, have_pend_next;
  logic              out_valid, out_valid_next;
  logic              best_found, best_found_next;
  logic              ret_tc, ret_tc_next;
  logic [NW-1:0]     n_res, n_res_next;
  logic [AW-1:0]     scan, scan_next;
  logic [AW-1:0]     pick, pick_next;

  // Payload state
  item_t                   cur, cur_next;
  logic [TASK_ID_BITS-1:0] run_task, run_task_next;
  logic [31:0]             run_dl, run_dl_next;
  logic [AW-1:0]           best_slot, best_slot_next;
  logic [31:0]             best_dl, best_dl_next;
  logic [TASK_ID_BITS-1:0] best_task, best_task_next;
  logic [SW-1:0]           ent, ent_next;
  result_t                 pend, pend_next;
  result_t                 out_r, out_next;

  // Decoded views
  logic [TASK_ID_BITS-1:0] id_m;
  logic [TASK_ID_BITS-1:0] sr_task;
  logic [31:0]             sr_dl;
  logic [31:0]             idx_w;
  logic [AW-1:0]           idx_a;
  logic                    free_found;
  logic [AW-1:0]           free_slot;
  logic                    out_free;
  logic [4:0]              ac;

  assign id_m     = TASK_ID_BITS'(64'(cur.task_id) & ID_MASK);
  assign sr_task  = slot_rd[SW-1:64];
  assign sr_dl    = slot_rd[31:0];
  assign idx_w    = 32'(cur.idx);
  assign idx_a    = idx_w[AW-1:0];
  assign out_free = !out_valid || result_ready;
  assign ac       = 5'(active_cnt);

  assign result_valid = out_valid;
  assign result       = out_r;

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = ACTIVE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_slot  = AW'(i);
      end
    end
  end

  // Result record builder
  function automatic result_t mk(input logic rp, input logic [15:0] rt,
                                 input logic [15:0] dem, input logic ev,
                                 input logic [SW-1:0] e, input logic [2:0] st,
                                 input logic [4:0] cnt, input logic [15:0] tot,
                                 input logic [31:0] idl);
    result_t r;
    r.run_task_id       = rp ? rt : 16'd0;
    r.run_valid         = rp;
    r.demoted_task_id   = dem;
    r.entry_task_id     = ev ? 16'(e[SW-1:64]) : 16'd0;
    r.entry_created_ms  = ev ? e[63:32] : 32'd0;
    r.entry_deadline_ms = ev ? e[31:0] : 32'd0;
    r.entry_valid       = ev;
    r.active_count      = cnt;
    r.overdue_count     = tot;
    r.idle_time_ms      = idl;
    r.status            = st;
    r.last              = 1'b0;
    return r;
  endfunction

  // Sequencer: next state and outputs
  always_comb begin
    logic [31:0]             dl;
    logic [31:0]             filled;
    logic [31:0]             rpos;
    logic                    take;
    logic                    b_found;
    logic [AW-1:0]           b_slot;
    logic [31:0]             b_dl;
    logic [TASK_ID_BITS-1:0] b_task;
    logic [SW-1:0]           new_ent;

    state_next       = state;
    valid_next       = valid;
    active_cnt_next  = active_cnt;
    run_present_next = run_present;
    run_slot_next    = run_slot;
    run_task_next    = run_task;
    run_dl_next      = run_dl;
    late_head_next   = late_head;
    late_total_next  = late_total;
    idle_next        = idle;
    prev_now_next    = prev_now;
    have_pend_next   = have_pend;
    out_valid_next   = out_valid && !result_ready;
    out_next         = out_r;
    best_found_next  = best_found;
    best_slot_next   = best_slot;
    best_dl_next     = best_dl;
    best_task_next   = best_task;
    ret_tc_next      = ret_tc;
    n_res_next       = n_res;
    scan_next        = scan;
    pick_next        = pick;
    cur_next         = cur;
    ent_next         = ent;
    pend_next        = pend;
    q_pop            = 1'b0;
    slot_we          = 1'b0;
    slot_wa          = free_slot;
    slot_wd          = '0;
    slot_ra          = scan;
    ring_we          = 1'b0;
    ring_wa          = late_head;
    ring_wd          = slot_rd;
    ring_ra          = '0;
    dl               = cur.now_ms + cur.rel_ms;
    filled           = (32'(late_total) < 32'(OVERDUE_DEPTH)) ? 32'(late_total)
                                                             : 32'(OVERDUE_DEPTH);
    rpos             = 32'(late_head) + 32'(OVERDUE_DEPTH) - 32'd1 - idx_w;
    if (rpos >= 32'(OVERDUE_DEPTH)) begin
      rpos = rpos - 32'(OVERDUE_DEPTH);
    end
    take             = valid[pick] && (!best_found || sr_dl < best_dl);
    b_found          = take ? 1'b1 : best_found;
    b_slot           = take ? pick : best_slot;
    b_dl             = take ? sr_dl : best_dl;
    b_task           = take ? sr_task : best_task;
    new_ent          = {id_m, cur.now_ms, dl};

    case (state)
      // Take the next command and accrue idle time
      S_IDLE: begin
        if (q_nonempty) begin
          q_pop          = 1'b1;
          cur_next       = q_item;
          if (active_cnt == '0) begin
            idle_next = idle + (q_item.now_ms - prev_now);
          end
          prev_now_next  = q_item.now_ms;
          scan_next      = '0;
          n_res_next     = '0;
          have_pend_next = 1'b0;
          case (q_item.op)
            OP_CREATE:    state_next = S_CREATE;
            OP_DELETE:    state_next = S_DEL_RD;
            OP_TCHECK:    state_next = S_TC_RD;
            OP_READ_ACT:  state_next = S_RA;
            OP_READ_LATE: state_next = S_RO;
            default:      state_next = S_NONE;
          endcase
        end
      end

      S_NONE: begin
        pend_next  = mk(run_present, 16'(run_task), 16'd0, 1'b0, '0, STAT_OK, ac,
                        late_total, idle);
        state_next = S_EMIT;
      end

      // Create: fill lowest free slot, preempt on strictly sooner deadline
      S_CREATE: begin
        if (!free_found) begin
          pend_next = mk(run_present, 16'(run_task), 16'd0, 1'b0, '0, STAT_FULL, ac,
                         late_total, idle);
        end else begin
          slot_we                = 1'b1;
          slot_wd                = new_ent;
          valid_next[free_slot]  = 1'b1;
          active_cnt_next        = active_cnt + 1'b1;
          if (!run_present || dl < run_dl) begin
            run_present_next = 1'b1;
            run_slot_next    = free_slot;
            run_task_next    = id_m;
            run_dl_next      = dl;
            pend_next = mk(1'b1, 16'(id_m),
                           run_present ? 16'(run_task) : 16'd0, 1'b1, new_ent,
                           run_present ? STAT_PREEMPT : STAT_OK,
                           5'(active_cnt + 1'b1), late_total, idle);
          end else begin
            pend_next = mk(1'b1, 16'(run_task), 16'd0, 1'b1, new_ent, STAT_OK,
                           5'(active_cnt + 1'b1), late_total, idle);
          end
        end
        state_next = S_EMIT;
      end

      // Delete: scan for the lowest slot with a matching id
      S_DEL_RD: begin
        state_next = S_DEL_CHK;
      end

      S_DEL_CHK: begin
        if (valid[scan] && sr_task == id_m) begin
          ent_next         = slot_rd;
          valid_next[scan] = 1'b0;
          active_cnt_next  = active_cnt - 1'b1;
          if (run_present && run_slot == scan) begin
            pick_next       = '0;
            best_found_next = 1'b0;
            ret_tc_next     = 1'b0;
            state_next      = S_PICK_RD;
          end else begin
            state_next = S_DEL_DONE;
          end
        end else if (scan == SLOT_LAST) begin
          pend_next  = mk(run_present, 16'(run_task), 16'd0, 1'b0, '0,
                          STAT_NOT_FOUND, ac, late_total, idle);
          state_next = S_EMIT;
        end else begin
          scan_next  = scan + 1'b1;
          state_next = S_DEL_RD;
        end
      end

      S_DEL_DONE: begin
        pend_next  = mk(run_present, 16'(run_task), 16'd0, 1'b1, ent, STAT_OK, ac,
                        late_total, idle);
        state_next = S_EMIT;
      end

      // Soonest-deadline search over all slots
      S_PICK_RD: begin
        slot_ra    = pick;
        state_next = S_PICK_CHK;
      end

      S_PICK_CHK: begin
        best_found_next = b_found;
        best_slot_next  = b_slot;
        best_dl_next    = b_dl;
        best_task_next  = b_task;
        if (pick == SLOT_LAST) begin
          run_present_next = b_found;
          run_slot_next    = b_found ? b_slot : '0;
          run_task_next    = b_task;
          run_dl_next      = b_dl;
          state_next       = ret_tc ? S_TC_HIT : S_DEL_DONE;
        end else begin
          pick_next  = pick + 1'b1;
          state_next = S_PICK_RD;
        end
      end

      // Time check: move expired slots to the overdue ring
      S_TC_RD: begin
        state_next = S_TC_CHK;
      end

      S_TC_CHK: begin
        if (valid[scan] && sr_dl <= cur.now_ms) begin
          ring_we          = 1'b1;
          late_head_next   = (late_head == RING_LAST) ? '0 : late_head + 1'b1;
          if (late_total != 16'hFFFF) begin
            late_total_next = late_total + 1'b1;
          end
          valid_next[scan] = 1'b0;
          active_cnt_next  = active_cnt - 1'b1;
          ent_next         = slot_rd;
          if (run_present && run_slot == scan) begin
            pick_next       = '0;
            best_found_next = 1'b0;
            ret_tc_next     = 1'b1;
            state_next      = S_PICK_RD;
          end else begin
            state_next = S_TC_HIT;
          end
        end else if (scan == SLOT_LAST) begin
          state_next = S_TC_END;
        end else begin
          scan_next  = scan + 1'b1;
          state_next = S_TC_RD;
        end
      end

      // Hold one result back so the final one can carry last
      S_TC_HIT: begin
        if (!have_pend || out_free) begin
          if (have_pend) begin
            out_next       = pend;
            out_next.last  = 1'b0;
            out_valid_next = 1'b1;
          end
          pend_next      = mk(run_present, 16'(run_task), 16'd0, 1'b1, ent, STAT_OK,
                              ac, late_total, idle);
          have_pend_next = 1'b1;
          n_res_next     = n_res + 1'b1;
          if (scan == SLOT_LAST || n_res + 1'b1 == NW'(RESULT_LIMIT)) begin
            state_next = S_TC_END;
          end else begin
            scan_next  = scan + 1'b1;
            state_next = S_TC_RD;
          end
        end
      end

      S_TC_END: begin
        if (!have_pend) begin
          pend_next = mk(run_present, 16'(run_task), 16'd0, 1'b0, '0, STAT_OK, ac,
                         late_total, idle);
        end
        state_next = S_EMIT;
      end

      // Read an active slot
      S_RA: begin
        slot_ra = idx_a;
        if (idx_w >= 32'(ACTIVE_DEPTH)) begin
          pend_next  = mk(run_present, 16'(run_task), 16'd0, 1'b0, '0, STAT_RANGE,
                          ac, late_total, idle);
          state_next = S_EMIT;
        end else if (!valid[idx_a]) begin
          pend_next  = mk(run_present, 16'(run_task), 16'd0, 1'b0, '0, STAT_OK, ac,
                          late_total, idle);
          state_next = S_EMIT;
        end else begin
          state_next = S_RA_DATA;
        end
      end

      // Entry data lands in the cycle after the address, from slot or ring
      S_RA_DATA: begin
        pend_next  = mk(run_present, 16'(run_task), 16'd0, 1'b1,
                        (cur.op == OP_READ_LATE) ? ring_rd : slot_rd, STAT_OK,
                        ac, late_total, idle);
        state_next = S_EMIT;
      end

      // Read an overdue entry, newest first
      S_RO: begin
        ring_ra = rpos[LW-1:0];
        if (idx_w >= 32'(OVERDUE_DEPTH)) begin
          pend_next  = mk(run_present, 16'(run_task), 16'd0, 1'b0, '0, STAT_RANGE,
                          ac, late_total, idle);
          state_next = S_EMIT;
        end else if (idx_w >= filled) begin
          pend_next  = mk(run_present, 16'(run_task), 16'd0, 1'b0, '0, STAT_OK, ac,
                          late_total, idle);
          state_next = S_EMIT;
        end else begin
          state_next = S_RA_DATA;
        end
      end

      // Final beat of the command
      S_EMIT: begin
        if (out_free) begin
          out_next       = pend;
          out_next.last  = 1'b1;
          out_valid_next = 1'b1;
          have_pend_next = 1'b0;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid       <= '0;
      active_cnt  <= '0;
      run_present <= 1'b0;
      run_slot    <= '0;
      late_head   <= '0;
      late_total  <= '0;
      idle        <= '0;
      prev_now    <= '0;
      have_pend   <= 1'b0;
      out_valid   <= 1'b0;
      best_found  <= 1'b0;
      ret_tc      <= 1'b0;
      n_res       <= '0;
      scan        <= '0;
      pick        <= '0;
    end else begin
      state       <= state_next;
      valid       <= valid_next;
      active_cnt  <= active_cnt_next;
      run_present <= run_present_next;
      run_slot    <= run_slot_next;
      late_head   <= late_head_next;
      late_total  <= late_total_next;
      idle        <= idle_next;
      prev_now    <= prev_now_next;
      have_pend   <= have_pend_next;
      out_valid   <= out_valid_next;
      best_found  <= best_found_next;
      ret_tc      <= ret_tc_next;
      n_res       <= n_res_next;
      scan        <= scan_next;
      pick        <= pick_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur       <= cur_next;
    run_task  <= run_task_next;
    run_dl    <= run_dl_next;
    best_slot <= best_slot_next;
    best_dl   <= best_dl_next;
    best_task <= best_task_next;
    ent       <= ent_next;
    out_r     <= out_next;
    pend      <= pend_next;
  end

  // Memories
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_rd <= ring_mem[ring_ra];
  end

endmodule
